// ===== design/ids_pkg.sv =====
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants for the interned day-set table.
// ----------------------------------------------------------------------------
package ids_pkg;

  // Table geometry
  localparam int DAYS    = 64;
  localparam int ENTRIES = 256;

  localparam int IDX_W  = $clog2(ENTRIES);      // entry index
  localparam int USED_W = $clog2(ENTRIES + 1);  // fill count, holds ENTRIES
  localparam int DCNT_W = $clog2(DAYS + 1);     // day count / window width
  localparam int SH_W   = $clog2(DAYS);         // bit position inside a set

  // Command codes
  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_INTERSECT = 3'd1,
    CMD_AND_NOT   = 3'd2,
    CMD_SHL       = 3'd3,
    CMD_SHR       = 3'd4,
    CMD_COMPARE   = 3'd5,
    CMD_NEXT_DAY  = 3'd6,
    CMD_READ      = 3'd7
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_DAY = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_OP,
    S_SCAN,
    S_NEXT,
    S_DONE
  } state_e;

  // Commands that produce a set to be interned
  function automatic logic makes_set(cmd_e cmd);
    logic r;
    r = (cmd inside {CMD_INSERT, CMD_INTERSECT, CMD_AND_NOT, CMD_SHL, CMD_SHR});
    return r;
  endfunction

endpackage

// ===== design/ids_ram.sv =====
// ----------------------------------------------------------------------------
// ids_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ids_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/ids_set_alu.sv =====
// ----------------------------------------------------------------------------
// ids_set_alu
// Set operations on two operands: builds the set to intern and the
// windowed compare result.
// ----------------------------------------------------------------------------
module ids_set_alu import ids_pkg::*; (
  input  cmd_e              cmd_i,
  input  logic [DAYS-1:0]   a_i,
  input  logic [DAYS-1:0]   b_i,
  input  logic [DCNT_W-1:0] count_i,
  input  logic [DCNT_W-1:0] width_i,
  input  logic [DAYS-1:0]   day_bits_i,
  output logic [DAYS-1:0]   made_o,
  output logic              equal_o
);

  logic [DAYS-1:0] win_mask;
  logic [DAYS-1:0] cmp_mask;
  logic            big_shift;

  // Window mask and compare mask, bit by bit
  always_comb begin
    for (int i = 0; i < DAYS; i++) begin
      win_mask[i] = (DCNT_W'(i) < width_i);
      cmp_mask[i] = (DCNT_W'(i) < width_i) && (DCNT_W'(i) >= count_i);
    end
  end

  assign big_shift = (count_i >= DCNT_W'(DAYS));

  // Set producing commands
  always_comb begin
    case (cmd_i)
      CMD_INSERT:    made_o = day_bits_i & win_mask;
      CMD_INTERSECT: made_o = a_i & b_i;
      CMD_AND_NOT:   made_o = a_i & ~b_i;
      CMD_SHL:       made_o = big_shift ? '0 : ((a_i << count_i[SH_W-1:0]) & win_mask);
      CMD_SHR:       made_o = big_shift ? '0 : ((a_i & win_mask) >> count_i[SH_W-1:0]);
      default:       made_o = '0;
    endcase
  end

  assign equal_o = ((a_i & cmp_mask) == (b_i & cmp_mask));

endmodule

// ===== design/interned_day_set_table.sv =====
// ----------------------------------------------------------------------------
// interned_day_set_table
// Table of unique day sets with deduplicating insert and set operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one command beat; output
//   channel (out_valid_o/out_ready_i) returns exactly one result beat per
//   command. cfg_we_i/cfg_wdata_i write active_days; write it only while idle.
//   One command is in flight at a time. in_ready_o is high whenever the
//   sequencer is idle, even while a finished result waits in the output
//   register.
// Sequence (accept to result valid, output not stalled):
//   compare, read          : RD_B, OP, DONE
//   next day               : RD_B, OP, S_NEXT at one day/cycle, DONE
//   insert and set ops     : RD_B, OP, S_SCAN, DONE; the dedup scan reads
//                            one table entry per cycle through the single
//                            RAM read port, up to entry k on a hit at entry
//                            k and all entries_used entries on a miss.
// Issue: one command at a time; the next beat is taken the cycle after the
//   result is loaded.
// Reset: entry 0 reads as the empty set, entries_used is 1, active_days is 64.
//   No clearing pass; the dedup scan never reads entries beyond entries_used.
// Stall: a held result keeps the output register; the next command finishes
//   and then waits in the done state until the output register frees.
// ----------------------------------------------------------------------------
module interned_day_set_table import ids_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic [IDX_W-1:0]  first_index_i,
  input  logic [IDX_W-1:0]  second_index_i,
  input  logic [DCNT_W-1:0] count_i,
  input  logic [DAYS-1:0]   day_bits_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  result_index_o,
  output logic [DAYS-1:0]   read_bits_o,
  output logic              is_equal_o,
  output logic [DCNT_W-1:0] next_day_o,
  output logic [1:0]        status_o,
  // configuration
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i
);

  state_e state_q, state_d;

  // command latch
  cmd_e              cmd_q, cmd_d;
  logic [IDX_W-1:0]  ib_q, ib_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DAYS-1:0]   bits_q, bits_d;
  logic [DCNT_W-1:0] w_q, w_d;

  // working registers
  logic [DAYS-1:0]   a_q, a_d;
  logic [DAYS-1:0]   made_q, made_d;
  logic [USED_W-1:0] k_q, k_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [DCNT_W-1:0] d_q, d_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [6:0]        cfg_q;

  // pending result
  logic [IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [DAYS-1:0]   res_rd_q, res_rd_d;
  logic              res_eq_q, res_eq_d;
  logic [DCNT_W-1:0] res_nd_q, res_nd_d;
  status_e           res_st_q, res_st_d;

  // output register
  logic              out_vld_q, out_vld_d;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DAYS-1:0]   out_rd_q;
  logic              out_eq_q;
  logic [DCNT_W-1:0] out_nd_q;
  status_e           out_st_q;
  logic              out_load;

  // RAM port
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DAYS-1:0]   ram_rdata, rdata_eff;
  logic              rd_zero_q;

  // helpers
  logic              accept, out_free;
  logic              scan_issue, scan_hit, scan_miss, table_full;
  logic [DCNT_W-1:0] w_now, start_day, day_pos;
  logic              day_over, day_hit;
  logic [DAYS-1:0]   alu_made;
  logic              alu_eq;

  // --------------------------------------------------------------------------
  // Storage and set unit
  // --------------------------------------------------------------------------
  ids_ram #(
    .WIDTH (DAYS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (made_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry 0 is never written and reads as the empty set
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_zero_q <= (ram_raddr == '0);
    end
  end
  assign rdata_eff = rd_zero_q ? '0 : ram_rdata;

  ids_set_alu u_alu (
    .cmd_i      (cmd_q),
    .a_i        (a_q),
    .b_i        (rdata_eff),
    .count_i    (cnt_q),
    .width_i    (w_q),
    .day_bits_i (bits_q),
    .made_o     (alu_made),
    .equal_o    (alu_eq)
  );

  // --------------------------------------------------------------------------
  // Helper terms
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign w_now      = (cfg_q > 7'(DAYS)) ? DCNT_W'(DAYS) : DCNT_W'(cfg_q);

  assign scan_issue = (k_q < used_q);
  assign scan_hit   = cmp_vld_q && (rdata_eff == made_q);
  assign scan_miss  = !cmp_vld_q && !scan_issue;
  assign table_full = (used_q >= USED_W'(ENTRIES));

  assign start_day  = (cnt_q == '0) ? DCNT_W'(1) : cnt_q;
  assign day_pos    = w_q - d_q;
  assign day_over   = (d_q > w_q);
  assign day_hit    = a_q[day_pos[SH_W-1:0]];

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RD_B;
      end
      S_RD_B: state_d = S_OP;
      S_OP: begin
        if (makes_set(cmd_q)) state_d = S_SCAN;
        else if (cmd_q == CMD_NEXT_DAY) state_d = S_NEXT;
        else state_d = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit || scan_miss) state_d = S_DONE;
      end
      S_NEXT: begin
        if (day_over || day_hit) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    cmd_d     = cmd_q;
    ib_d      = ib_q;
    cnt_d     = cnt_q;
    bits_d    = bits_q;
    w_d       = w_q;
    a_d       = a_q;
    made_d    = made_q;
    k_d       = k_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    d_d       = d_q;
    used_d    = used_q;
    res_idx_d = res_idx_q;
    res_rd_d  = res_rd_q;
    res_eq_d  = res_eq_q;
    res_nd_d  = res_nd_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    ram_waddr = used_q[IDX_W-1:0];
    ram_re    = 1'b0;
    ram_raddr = first_index_i;
    out_load  = 1'b0;

    case (state_q)
      // latch the beat and fetch the first operand
      S_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_e'(command_i);
          ib_d      = second_index_i;
          cnt_d     = count_i;
          bits_d    = day_bits_i;
          w_d       = w_now;
          ram_re    = 1'b1;
          ram_raddr = first_index_i;
          res_idx_d = first_index_i;
          res_rd_d  = '0;
          res_eq_d  = 1'b0;
          res_nd_d  = '0;
          res_st_d  = ST_OK;
        end
      end
      // capture first operand, fetch second
      S_RD_B: begin
        a_d       = rdata_eff;
        ram_re    = 1'b1;
        ram_raddr = ib_q;
      end
      // operate with second operand straight from the RAM
      S_OP: begin
        made_d   = alu_made;
        k_d      = '0;
        d_d      = start_day;
        res_eq_d = (cmd_q == CMD_COMPARE) ? alu_eq : 1'b0;
        res_rd_d = (cmd_q == CMD_READ) ? a_q : '0;
      end
      // dedup scan: read entry k, compare entry k-1
      S_SCAN: begin
        if (scan_issue) begin
          ram_re    = 1'b1;
          ram_raddr = k_q[IDX_W-1:0];
          k_d       = k_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = k_q[IDX_W-1:0];
        end
        if (scan_hit) begin
          res_idx_d = cmp_idx_q;
        end else if (scan_miss) begin
          if (table_full) begin
            res_idx_d = '0;
            res_st_d  = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            res_idx_d = used_q[IDX_W-1:0];
            used_d    = used_q + 1'b1;
          end
        end
      end
      // next day: one window bit per cycle, day 1 is the top window bit
      S_NEXT: begin
        if (day_over) begin
          res_st_d = ST_NO_DAY;
        end else if (day_hit) begin
          res_nd_d = d_q;
        end else begin
          d_d = d_q + 1'b1;
        end
      end
      S_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= USED_W'(1);
      cfg_q     <= 7'(DAYS);
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    ib_q      <= ib_d;
    cnt_q     <= cnt_d;
    bits_q    <= bits_d;
    w_q       <= w_d;
    a_q       <= a_d;
    made_q    <= made_d;
    k_q       <= k_d;
    cmp_idx_q <= cmp_idx_d;
    d_q       <= d_d;
    res_idx_q <= res_idx_d;
    res_rd_q  <= res_rd_d;
    res_eq_q  <= res_eq_d;
    res_nd_q  <= res_nd_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_idx_q <= res_idx_q;
      out_rd_q  <= res_rd_q;
      out_eq_q  <= res_eq_q;
      out_nd_q  <= res_nd_q;
      out_st_q  <= res_st_q;
    end
  end

  // result beat
  assign out_valid_o    = out_vld_q;
  assign result_index_o = out_idx_q;
  assign read_bits_o    = out_rd_q;
  assign is_equal_o     = out_eq_q;
  assign next_day_o     = out_nd_q;
  assign status_o       = out_st_q;

endmodule

// ===== design/ids_checker.sv =====
// ----------------------------------------------------------------------------
// ids_checker
// Port-level checks for the interned day-set table, bound to the top level.
// ----------------------------------------------------------------------------
module ids_checker import ids_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [IDX_W-1:0]  result_index_o,
  input logic [DCNT_W-1:0] next_day_o,
  input logic [1:0]        status_o
);

  // a held result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // one command at a time: no new beat right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command accepted back to back");

  // full table reports index zero
  a_full_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (result_index_o == '0))
    else $error("full status with nonzero index");

  // no day found reports day zero
  a_no_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NO_DAY) |-> (next_day_o == '0))
    else $error("no-day status with nonzero day");

endmodule

bind interned_day_set_table ids_checker u_ids_checker (.*);
